### src/rai_pkg.sv
// ----------------------------------------------------------------------------
// rai_pkg
// Shared types, register indexes and helpers of the ray/annulus unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rai_pkg;

  localparam logic [1:0] REG_INNER = 2'd0;
  localparam logic [1:0] REG_OUTER = 2'd1;
  localparam logic [1:0] REG_THICK = 2'd2;

  localparam logic [30:0] MAX31 = 31'h7fffffff;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } ray_t;

  typedef struct packed {
    ray_t        ray;
    logic [30:0] t;
    logic        miss;
  } span_t;

  typedef struct packed {
    logic signed [31:0] hx;
    logic signed [31:0] hz;
    logic [31:0]        hy_mag;
    logic [63:0]        sq;
    logic [30:0]        t;
    logic               miss;
  } pnt_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic [30:0] radius;
    logic [15:0] angle;
  } res_t;

  typedef struct packed {
    logic [30:0] inner;
    logic [30:0] outer;
    logic [30:0] thick;
  } cfg_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // atan(2^-i), pi = 2^31
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### src/rai_div.sv
// ----------------------------------------------------------------------------
// rai_div
// Miss pre-checks and pipelined restoring divider for t = |oy|<<F / |dy|.
// ----------------------------------------------------------------------------
`default_nettype none
module rai_div import rai_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire ray_t  ray_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output span_t      out_o
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = DW + 32;
  localparam int NS = 32;

  typedef struct packed {
    ray_t          ray;
    logic          miss;
    logic          sat;
    logic [31:0]   dvs;
    logic [DW-1:0] rem;
    logic [30:0]   quo;
  } dst_t;

  dst_t          s_q [NS];
  dst_t          s_d [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    logic [31:0]   oy_m;
    logic [CW-1:0] den;
    oy_m = mag32(ray_i.oy);
    s_d[0].ray  = ray_i;
    s_d[0].miss = (ray_i.dy == 32'sd0) ||
                  ((ray_i.oy != 32'sd0) && (ray_i.oy[31] == ray_i.dy[31]));
    s_d[0].dvs  = mag32(ray_i.dy);
    s_d[0].rem  = DW'(oy_m) << FRAC_BITS;
    s_d[0].quo  = '0;
    s_d[0].sat  = CW'(s_d[0].rem) >= (CW'(s_d[0].dvs) << 31);
    for (int k = 1; k < NS; k++) begin
      s_d[k] = s_q[k-1];
      den = CW'(s_q[k-1].dvs) << (31 - k);
      if (CW'(s_q[k-1].rem) >= den) begin
        s_d[k].rem = DW'(CW'(s_q[k-1].rem) - den);
        s_d[k].quo[31-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) s_q[k] <= s_d[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o.ray   = s_q[NS-1].ray;
  assign out_o.t     = s_q[NS-1].sat ? MAX31 : s_q[NS-1].quo;
  assign out_o.miss  = s_q[NS-1].miss;

endmodule
`default_nettype wire

### src/rai_adv.sv
// ----------------------------------------------------------------------------
// rai_adv
// Hit point h = o + t*d (saturated) and the squared radius, four stages.
// ----------------------------------------------------------------------------
`default_nettype none
module rai_adv import rai_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire span_t in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output pnt_t       out_o
);

  localparam int NS = 4;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic               sx;
    logic               sy;
    logic               sz;
    logic [62:0]        px;
    logic [62:0]        py;
    logic [62:0]        pz;
    pnt_t               p;
  } ast_t;

  ast_t          s_q [NS];
  ast_t          s_d [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  function automatic logic signed [31:0] step(input logic signed [31:0] o,
                                              input logic sn,
                                              input logic [62:0] p);
    logic signed [63:0] m;
    m = $signed({1'b0, 63'(p >> FRAC_BITS)});
    return sat32(64'(o) + (sn ? -m : m));
  endfunction

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    s_d[0]        = s_q[0];
    s_d[0].ox     = in_i.ray.ox;
    s_d[0].oy     = in_i.ray.oy;
    s_d[0].oz     = in_i.ray.oz;
    s_d[0].sx     = in_i.ray.dx[31];
    s_d[0].sy     = in_i.ray.dy[31];
    s_d[0].sz     = in_i.ray.dz[31];
    s_d[0].px     = 63'(in_i.t) * 63'(mag32(in_i.ray.dx));
    s_d[0].py     = 63'(in_i.t) * 63'(mag32(in_i.ray.dy));
    s_d[0].pz     = 63'(in_i.t) * 63'(mag32(in_i.ray.dz));
    s_d[0].p.t    = in_i.t;
    s_d[0].p.miss = in_i.miss;

    s_d[1]          = s_q[0];
    s_d[1].p.hx     = step(s_q[0].ox, s_q[0].sx, s_q[0].px);
    s_d[1].p.hz     = step(s_q[0].oz, s_q[0].sz, s_q[0].pz);
    s_d[1].p.hy_mag = mag32(step(s_q[0].oy, s_q[0].sy, s_q[0].py));

    // squares held in px/pz lanes
    s_d[2]    = s_q[1];
    s_d[2].px = 63'(64'(mag32(s_q[1].p.hx)) * 64'(mag32(s_q[1].p.hx)));
    s_d[2].pz = 63'(64'(mag32(s_q[1].p.hz)) * 64'(mag32(s_q[1].p.hz)));

    s_d[3]      = s_q[2];
    s_d[3].p.sq = 64'(s_q[2].px) + 64'(s_q[2].pz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) s_q[k] <= s_d[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = s_q[NS-1].p;

endmodule
`default_nettype wire

### src/rai_root.sv
// ----------------------------------------------------------------------------
// rai_root
// Pipelined integer square root with CORDIC azimuth alongside, then the
// annulus and thickness tests and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rai_root import rai_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire pnt_t  in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_o
);

  localparam int NS = 34;

  typedef struct packed {
    logic [63:0]        v;
    logic [63:0]        r;
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic signed [33:0] acc;
    logic               zero;
    logic [31:0]        hy_mag;
    logic [30:0]        t;
    logic               miss;
    res_t               res;
  } rst_t;

  rst_t          s_q [NS];
  rst_t          s_d [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    logic signed [34:0] ex;
    logic signed [34:0] ez;
    logic signed [34:0] ddx;
    logic signed [34:0] ddy;
    logic [63:0]        b;
    logic [64:0]        rb;
    logic [63:0]        r_c;
    logic signed [33:0] a_r;
    logic               bad;

    ex = 35'(in_i.hx);
    ez = 35'(in_i.hz);
    s_d[0]        = s_q[0];
    s_d[0].v      = in_i.sq;
    s_d[0].r      = '0;
    s_d[0].zero   = (in_i.hx == 32'sd0) && (in_i.hz == 32'sd0);
    s_d[0].hy_mag = in_i.hy_mag;
    s_d[0].t      = in_i.t;
    s_d[0].miss   = in_i.miss;
    s_d[0].x      = ex;
    s_d[0].y      = ez;
    s_d[0].acc    = '0;
    // quarter-turn into the right half plane
    if (ex < 0) begin
      if (ez >= 0) begin
        s_d[0].x   = ez;
        s_d[0].y   = -ex;
        s_d[0].acc = 34'sd1073741824;
      end else begin
        s_d[0].x   = -ez;
        s_d[0].y   = ex;
        s_d[0].acc = -34'sd1073741824;
      end
    end

    for (int k = 1; k < NS - 1; k++) begin
      s_d[k] = s_q[k-1];
      b  = 64'd1 << (2 * (32 - k));
      rb = {1'b0, s_q[k-1].r} + {1'b0, b};
      if ({1'b0, s_q[k-1].v} >= rb) begin
        s_d[k].v = s_q[k-1].v - 64'(rb);
        s_d[k].r = (s_q[k-1].r >> 1) + b;
      end else begin
        s_d[k].r = s_q[k-1].r >> 1;
      end
      if (k <= CORDIC_STEPS) begin
        ddx = s_q[k-1].y >>> (k - 1);
        ddy = s_q[k-1].x >>> (k - 1);
        if (s_q[k-1].y > 0) begin
          s_d[k].x   = s_q[k-1].x + ddx;
          s_d[k].y   = s_q[k-1].y - ddy;
          s_d[k].acc = s_q[k-1].acc + $signed({2'b00, atan_lut(5'(k - 1))});
        end else begin
          s_d[k].x   = s_q[k-1].x - ddx;
          s_d[k].y   = s_q[k-1].y + ddy;
          s_d[k].acc = s_q[k-1].acc - $signed({2'b00, atan_lut(5'(k - 1))});
        end
      end
    end

    s_d[NS-1] = s_q[NS-2];
    r_c = (s_q[NS-2].r > 64'(MAX31)) ? 64'(MAX31) : s_q[NS-2].r;
    bad = s_q[NS-2].miss || (r_c < 64'(cfg_i.inner)) || (r_c > 64'(cfg_i.outer)) ||
          (s_q[NS-2].hy_mag > 32'(cfg_i.thick));
    a_r = s_q[NS-2].acc + 34'sd32768;
    s_d[NS-1].res.hit      = !bad;
    s_d[NS-1].res.distance = bad ? '0 : s_q[NS-2].t;
    s_d[NS-1].res.radius   = bad ? '0 : r_c[30:0];
    s_d[NS-1].res.angle    = (bad || s_q[NS-2].zero) ? '0 : a_r[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) s_q[k] <= s_d[k];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = s_q[NS-1].res;

endmodule
`default_nettype wire

### src/ray_annulus_intersection_unit.sv
// ----------------------------------------------------------------------------
// ray_annulus_intersection_unit
// Ray against plane y=0 annulus: distance, radius and CORDIC azimuth.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  ray     | in        | in_valid_i/in_ready_o  | origin_*_i, dir_*_i
//  result  | out       | out_valid_o/out_ready_i| hit_o, hit_distance_o, ...
//  config  | in        | APB psel/penable       | paddr, pwdata, prdata
//
//  One request per cycle unless the output stalls; requests pass the
//  divider, hit point and square root/CORDIC stages and the result register.
//  Each stage advances when empty or when the next one moves, so bubbles
//  collapse; a stalled output blocks the input once all 70 stages are full.
//  Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_annulus_intersection_unit import rai_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic signed [31:0] origin_z_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    hit_o,
  output logic [30:0]             hit_distance_o,
  output logic [30:0]             hit_radius_o,
  output logic signed [15:0]      hit_angle_o
);

  cfg_t  cfg_q;
  ray_t  ray;
  span_t span;
  pnt_t  pnt;
  res_t  res;
  logic  span_valid, span_ready, pnt_valid, pnt_ready;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner <= '0;
      cfg_q.outer <= MAX31;
      cfg_q.thick <= 31'd32768;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_INNER: cfg_q.inner <= pwdata[30:0];
        REG_OUTER: cfg_q.outer <= pwdata[30:0];
        REG_THICK: cfg_q.thick <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INNER: prdata = {1'b0, cfg_q.inner};
      REG_OUTER: prdata = {1'b0, cfg_q.outer};
      REG_THICK: prdata = {1'b0, cfg_q.thick};
      default:   prdata = '0;
    endcase
  end

  assign ray.ox = origin_x_i;
  assign ray.oy = origin_y_i;
  assign ray.oz = origin_z_i;
  assign ray.dx = dir_x_i;
  assign ray.dy = dir_y_i;
  assign ray.dz = dir_z_i;

  rai_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .ray_i(ray),
    .out_valid_o(span_valid), .out_ready_i(span_ready), .out_o(span)
  );

  rai_adv #(.FRAC_BITS(FRAC_BITS)) u_adv (
    .clk_i, .rst_ni,
    .in_valid_i(span_valid), .in_ready_o(span_ready), .in_i(span),
    .out_valid_o(pnt_valid), .out_ready_i(pnt_ready), .out_o(pnt)
  );

  rai_root #(.CORDIC_STEPS(CORDIC_STEPS)) u_root (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(pnt_valid), .in_ready_o(pnt_ready), .in_i(pnt),
    .out_valid_o, .out_ready_i, .out_o(res)
  );

  assign hit_o          = res.hit;
  assign hit_distance_o = res.distance;
  assign hit_radius_o   = res.radius;
  assign hit_angle_o    = res.angle;

endmodule
`default_nettype wire

### src/rai_chk.sv
// ----------------------------------------------------------------------------
// rai_chk
// Port-level checks of the ray/annulus unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rai_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               hit_o,
  input wire logic [30:0]        hit_distance_o,
  input wire logic [30:0]        hit_radius_o,
  input wire logic signed [15:0] hit_angle_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_distance_o == '0 && hit_radius_o == '0 &&
    hit_angle_o == '0)
    else $error("miss result carries nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
    $stable(hit_distance_o) && $stable(hit_radius_o) && $stable(hit_angle_o))
    else $error("stalled result changed");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

endmodule

bind ray_annulus_intersection_unit rai_chk u_chk (.*);
`default_nettype wire

### test/tb_ray_annulus_intersection_unit.sv
// ----------------------------------------------------------------------------
// tb_ray_annulus_intersection_unit
// Random and directed rays against the annulus unit, checked in order
// against a behavioral model of the plane crossing, radius and azimuth.
// ----------------------------------------------------------------------------
`default_nettype none

class annulus_scoreboard;
  rai_pkg::cfg_t cfg;
  rai_pkg::res_t pending_q[$];
  int errors;

  function new();
    cfg.inner = 31'd0;
    cfg.outer = rai_pkg::MAX31;
    cfg.thick = 31'd32768;
    errors = 0;
  endfunction

  static function longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  static function longint move_axis(longint o, longint unsigned t, longint d);
    longint unsigned p;
    longint unsigned m;
    longint s;
    m = d < 0 ? longint'(-d) : longint'(d);
    p = (t * m) >> 16;
    s = d < 0 ? -longint'(p) : longint'(p);
    s = o + s;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  static function longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function logic [15:0] azimuth(longint x, longint y);
    longint acc;
    longint nx;
    longint ddx;
    longint ddy;
    acc = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; x = nx; acc = 64'sd1073741824;
      end else begin
        nx = -y; y = x; x = nx; acc = -64'sd1073741824;
      end
    end
    for (int i = 0; i < 16; i++) begin
      ddx = floor_shift(y, i);
      ddy = floor_shift(x, i);
      if (y > 0) begin
        x += ddx; y -= ddy; acc += longint'(rai_pkg::atan_lut(5'(i)));
      end else begin
        x -= ddx; y += ddy; acc -= longint'(rai_pkg::atan_lut(5'(i)));
      end
    end
    return 16'(floor_shift(acc + 32768, 16));
  endfunction

  function void note_ray(rai_pkg::ray_t r);
    rai_pkg::res_t e;
    longint oy, dy, hx, hy, hz;
    longint unsigned t, rad, mx, mz, my;
    e = '0;
    oy = longint'(r.oy);
    dy = longint'(r.dy);
    if (dy != 0 && !(oy != 0 && ((oy < 0) == (dy < 0)))) begin
      t = ((oy < 0 ? -oy : oy) << 16) / (dy < 0 ? -dy : dy);
      if (t > 64'h7fffffff) t = 64'h7fffffff;
      hx = move_axis(longint'(r.ox), t, longint'(r.dx));
      hy = move_axis(oy, t, dy);
      hz = move_axis(longint'(r.oz), t, longint'(r.dz));
      mx = hx < 0 ? -hx : hx;
      mz = hz < 0 ? -hz : hz;
      my = hy < 0 ? -hy : hy;
      rad = root_floor(mx * mx + mz * mz);
      if (rad > 64'h7fffffff) rad = 64'h7fffffff;
      if (!(rad < cfg.inner || rad > cfg.outer) && my <= cfg.thick) begin
        e.hit = 1'b1;
        e.distance = 31'(t);
        e.radius = 31'(rad);
        e.angle = azimuth(hx, hz);
      end
    end
    pending_q.push_back(e);
  endfunction

  function void check_result(rai_pkg::res_t got);
    rai_pkg::res_t e;
    if (pending_q.size() == 0) begin
      $error("result with none pending");
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.hit !== e.hit) begin
      $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
    end
    if (got.distance !== e.distance) begin
      $error("hit_distance exp %0d got %0d", e.distance, got.distance); errors++;
    end
    if (got.radius !== e.radius) begin
      $error("hit_radius exp %0d got %0d", e.radius, got.radius); errors++;
    end
    if (got.angle !== e.angle) begin
      $error("hit_angle exp %0d got %0d", $signed(e.angle), $signed(got.angle));
      errors++;
    end
  endfunction
endclass

module tb_ray_annulus_intersection_unit;
  import rai_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ray_t ray = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic [30:0] hit_distance_o, hit_radius_o;
  logic signed [15:0] hit_angle_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  annulus_scoreboard sb = new();

  always #2 clk_i = ~clk_i;

  ray_annulus_intersection_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .origin_x_i(ray.ox), .origin_y_i(ray.oy), .origin_z_i(ray.oz),
    .dir_x_i(ray.dx), .dir_y_i(ray.dy), .dir_z_i(ray.dz),
    .out_valid_o, .out_ready_i,
    .hit_o, .hit_distance_o, .hit_radius_o, .hit_angle_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({hit_o, hit_distance_o, hit_radius_o, hit_angle_o});
  end

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_INNER) sb.cfg.inner = v[30:0];
    else if (idx == REG_OUTER) sb.cfg.outer = v[30:0];
    else if (idx == REG_THICK) sb.cfg.thick = v[30:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send_ray(ray_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ray <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_ray(r);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom();
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // mostly plane-crossing rays landing near the disk
  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = pick_word(); r.oz = pick_word();
    r.dx = pick_word(); r.dz = pick_word();
    r.oy = pick_word(); r.dy = pick_word();
    if ($urandom_range(9) < 7) begin
      r.oy = 32'($signed($urandom_range(800000)) - 400000);
      r.dy = (r.oy < 0) ? 32'($urandom_range(300000, 1))
                        : -32'($urandom_range(300000, 1));
      if ($urandom_range(3) == 0) r.oy = 32'($signed($urandom_range(2)) - 1);
      r.dx = 32'($signed($urandom_range(200000)) - 100000);
      r.dz = 32'($signed($urandom_range(200000)) - 100000);
      r.ox = 32'($signed($urandom_range(20000000)) - 10000000);
      r.oz = 32'($signed($urandom_range(20000000)) - 10000000);
    end
    return r;
  endfunction

  task automatic run_random(int n);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_ray();
      send_ray(r);
    end
  endtask

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: parallel, behind, origin on plane, extremes, hit at center
    send_ray('{ox: 0, oy: 32'h10000, oz: 0, dx: 0, dy: 0, dz: 0});
    send_ray('{ox: 0, oy: 32'h10000, oz: 0, dx: 0, dy: 32'h10000, dz: 0});
    send_ray('{ox: 0, oy: -32'h10000, oz: 0, dx: 0, dy: -32'h10000, dz: 0});
    send_ray('{ox: 0, oy: 32'h10000, oz: 0, dx: 0, dy: -32'h10000, dz: 0});
    send_ray('{ox: 32'h30000, oy: 0, oz: 32'h40000, dx: 1, dy: 1, dz: 1});
    send_ray('{ox: -32'h10000, oy: 0, oz: 0, dx: 0, dy: 5, dz: 0});
    send_ray('{ox: -32'h10000, oy: 0, oz: -1, dx: 0, dy: 5, dz: 0});
    send_ray('{ox: -32'h10000, oy: 0, oz: 1, dx: 0, dy: 5, dz: 0});
    send_ray('{ox: 32'h8000_0000, oy: 32'h7fff_ffff, oz: 32'h7fff_ffff,
               dx: 32'h8000_0000, dy: 32'h8000_0000, dz: 32'h7fff_ffff});
    send_ray('{ox: 32'h7fff_ffff, oy: 32'h8000_0000, oz: 32'h8000_0000,
               dx: 32'h7fff_ffff, dy: 1, dz: 32'h8000_0000});
    send_ray('{ox: 0, oy: 32'h7fff_ffff, oz: 0, dx: 1, dy: -1, dz: -1});
    send_ray('{ox: 32'hffff_ffff, oy: 32'hffff_ffff, oz: 32'hffff_ffff,
               dx: 32'hffff_ffff, dy: 32'h1, dz: 32'hffff_ffff});
    drain();

    write_reg(REG_INNER, 32'h0002_0000);
    write_reg(REG_OUTER, 32'h0001_0000);
    send_ray('{ox: 32'h18000, oy: 0, oz: 0, dx: 0, dy: 1, dz: 0});
    drain();
    write_reg(REG_INNER, 32'h0000_8000);
    write_reg(REG_OUTER, 32'h0080_0000);
    write_reg(REG_THICK, 32'h7fff_ffff);
    write_reg(2'd3, 32'h1234_5678);

    send_idle_pct = 7; recv_idle_pct = 55;
    run_random(350);
    drain();

    write_reg(REG_INNER, 32'h0);
    write_reg(REG_OUTER, 32'hffff_ffff);
    write_reg(REG_THICK, 32'h0);
    send_idle_pct = 55; recv_idle_pct = 7;
    run_random(350);

    // long receiver stall while rays keep coming
    hold_off = 300;
    send_idle_pct = 0;
    run_random(150);
    drain();

    write_reg(REG_INNER, 32'h0010_0000);
    write_reg(REG_OUTER, 32'h7fff_ffff);
    write_reg(REG_THICK, 32'h0000_4000);
    recv_idle_pct = 0;
    run_random(300);
    drain();

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### sim.f
src/rai_pkg.sv
src/rai_div.sv
src/rai_adv.sv
src/rai_root.sv
src/ray_annulus_intersection_unit.sv
src/rai_chk.sv
test/tb_ray_annulus_intersection_unit.sv
